// ===== rtl/pmc_pkg.sv =====
`default_nettype none

package pmc_pkg;

   localparam int unsigned COL_W      = 7;
   localparam int unsigned ROW_W      = 6;
   localparam int unsigned BTN_W      = 3;
   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned CSR_IDX_W  = 1;
   localparam int unsigned CSR_DATA_W = 7;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_COL = 1'b0,
      CSR_MAX_ROW = 1'b1
   } csr_index_type;

   typedef enum logic {
      FUNC_MOUSE_BYTE = 1'b0,
      FUNC_SET_POS    = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      POS_HEADER = 2'd0,
      POS_X      = 2'd1,
      POS_Y      = 2'd2
   } byte_pos_type;

   localparam logic [BYTE_W-1:0] SYNC_MASK     = 8'h08;
   localparam logic [BYTE_W-1:0] OVERFLOW_MASK = 8'hC0;
   localparam logic [BYTE_W-1:0] BUTTON_MASK   = 8'h07;

   localparam logic [COL_W-1:0] MAX_COL_RESET = 7'd78;
   localparam logic [ROW_W-1:0] MAX_ROW_RESET = 6'd23;
   localparam logic [COL_W-1:0] COL_RESET     = 7'd39;
   localparam logic [ROW_W-1:0] ROW_RESET     = 6'd12;

   typedef struct packed {
      logic              func;
      logic [BYTE_W-1:0] data_byte;
      logic [BYTE_W-1:0] new_row;
      logic [BYTE_W-1:0] new_col;
   } req_payload_type;

   typedef struct packed {
      logic [ROW_W-1:0] cursor_row;
      logic [COL_W-1:0] cursor_col;
      logic [BTN_W-1:0] button_bits;
      logic             updated;
      logic             overflow_drop;
   } rsp_payload_type;

endpackage

`default_nettype wire

// ===== rtl/pmc_req_if.sv =====
`default_nettype none

interface pmc_req_if;
   logic                     valid;
   logic                     ready;
   pmc_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/pmc_rsp_if.sv =====
`default_nettype none

interface pmc_rsp_if;
   logic                     valid;
   logic                     ready;
   pmc_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/ps2_mouse_packet_cursor.sv =====
`default_nettype none

// PS/2 mouse packet decoder with a text-cell cursor. Each request carries
// either one raw mouse byte or a set-position command, and produces exactly
// one response with the cursor row, column and buttons after that request.
// The packet state and cursor update in the cycle of acceptance, and the
// response sits in a single output register, so a new request is taken
// every cycle as long as the response side drains (ready is held low only
// while an untaken response blocks that register). A good three-byte
// packet moves the cursor one cell per two mouse counts, positive y moving
// toward row 0; packets with an overflow bit are reported by overflow_drop
// and otherwise ignored. The user must write max_col and max_row through the
// csr port only while no request is in flight; the block does not enforce it.
module ps2_mouse_packet_cursor (
   input  wire logic                             clock,
   input  wire logic                             reset,
   pmc_req_if.sink                               req_chan,
   pmc_rsp_if.source                             rsp_chan,
   input  wire logic                             csr_we,
   input  wire logic [pmc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [pmc_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import pmc_pkg::*;

   logic [1:0]        byte_pos_ff, byte_pos_in;
   logic [BYTE_W-1:0] header_ff, header_in;
   logic [BYTE_W-1:0] x_byte_ff, x_byte_in;
   logic [1:0]        res_x_ff, res_x_in;
   logic [1:0]        res_y_ff, res_y_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [BTN_W-1:0]  buttons_ff, buttons_in;
   logic [COL_W-1:0]  max_col_ff;
   logic [ROW_W-1:0]  max_row_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_payload_ff, rsp_payload_in;

   logic              accept;
   req_payload_type   req;
   logic signed [8:0] sum_x, sum_y;
   logic signed [8:0] cnt_x, cnt_y;
   logic [6:0]        mag_x, mag_y;
   logic [6:0]        col_moved, row_moved;
   logic [1:0]        res_x_new, res_y_new;
   logic              updated, dropped;

   // Saturating one-axis step; "up" moves toward lim and never past it.
   function automatic logic [6:0] step_pos(input logic [6:0] pos,
                                           input logic [6:0] lim,
                                           input logic       up,
                                           input logic [6:0] mag);
      logic [7:0] sum;
      logic [6:0] result;
      sum = {1'b0, pos} + {1'b0, mag};
      if (up) begin
         if (pos >= lim)
            result = pos;
         else if (sum >= {1'b0, lim})
            result = lim;
         else
            result = sum[6:0];
      end else begin
         if (mag >= pos)
            result = '0;
         else
            result = pos - mag;
      end
      return result;
   endfunction

   // Residual plus signed delta, halved toward zero; remainder keeps the sign.
   function automatic logic signed [8:0] halve(input logic signed [8:0] s);
      logic signed [8:0] adj;
      adj = s + (s[8] ? 9'sd1 : 9'sd0);
      return adj >>> 1;
   endfunction

   function automatic logic [1:0] remainder(input logic signed [8:0] s);
      return s[0] ? (s[8] ? 2'b11 : 2'b01) : 2'b00;
   endfunction

   assign req      = req_chan.payload;
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept   = req_chan.valid && req_chan.ready;

   assign sum_x = $signed({{7{res_x_ff[1]}}, res_x_ff}) + $signed({x_byte_ff[7], x_byte_ff});
   assign sum_y = $signed({{7{res_y_ff[1]}}, res_y_ff})
                  + $signed({req.data_byte[7], req.data_byte});
   assign cnt_x = halve(sum_x);
   assign cnt_y = halve(sum_y);
   assign mag_x = cnt_x[8] ? 7'(-cnt_x) : cnt_x[6:0];
   assign mag_y = cnt_y[8] ? 7'(-cnt_y) : cnt_y[6:0];
   assign res_x_new = remainder(sum_x);
   assign res_y_new = remainder(sum_y);

   assign col_moved = step_pos(col_ff, max_col_ff, !cnt_x[8], mag_x);
   // positive y moves toward row 0
   assign row_moved = step_pos({1'b0, row_ff}, {1'b0, max_row_ff}, cnt_y[8], mag_y);

   always_comb begin
      byte_pos_in = byte_pos_ff;
      header_in   = header_ff;
      x_byte_in   = x_byte_ff;
      res_x_in    = res_x_ff;
      res_y_in    = res_y_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      buttons_in  = buttons_ff;
      updated     = 1'b0;
      dropped     = 1'b0;
      if (accept) begin
         if (req.func == FUNC_SET_POS) begin
            row_in  = (req.new_row > {2'b00, max_row_ff}) ? max_row_ff : req.new_row[ROW_W-1:0];
            col_in  = (req.new_col > {1'b0, max_col_ff}) ? max_col_ff : req.new_col[COL_W-1:0];
            updated = 1'b1;
         end else begin
            case (byte_pos_ff)
               POS_HEADER: begin
                  // drop a header without the sync bit
                  if ((req.data_byte & SYNC_MASK) != '0) begin
                     header_in   = req.data_byte;
                     byte_pos_in = POS_X;
                  end
               end
               POS_X: begin
                  x_byte_in   = req.data_byte;
                  byte_pos_in = POS_Y;
               end
               default: begin
                  byte_pos_in = POS_HEADER;
                  if ((header_ff & SYNC_MASK) != '0) begin
                     if ((header_ff & OVERFLOW_MASK) != '0) begin
                        dropped = 1'b1;
                     end else begin
                        res_x_in   = res_x_new;
                        res_y_in   = res_y_new;
                        buttons_in = header_ff[BTN_W-1:0] & BUTTON_MASK[BTN_W-1:0];
                        col_in     = col_moved;
                        row_in     = row_moved[ROW_W-1:0];
                        updated    = 1'b1;
                     end
                  end
               end
            endcase
         end
      end
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_payload_in = rsp_payload_ff;
      if (accept) begin
         rsp_valid_in                 = 1'b1;
         rsp_payload_in.cursor_row    = row_in;
         rsp_payload_in.cursor_col    = col_in;
         rsp_payload_in.button_bits   = buttons_in;
         rsp_payload_in.updated       = updated;
         rsp_payload_in.overflow_drop = dropped;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_pos_ff  <= POS_HEADER;
         header_ff    <= '0;
         x_byte_ff    <= '0;
         res_x_ff     <= '0;
         res_y_ff     <= '0;
         row_ff       <= ROW_RESET;
         col_ff       <= COL_RESET;
         buttons_ff   <= '0;
         max_col_ff   <= MAX_COL_RESET;
         max_row_ff   <= MAX_ROW_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         byte_pos_ff  <= byte_pos_in;
         header_ff    <= header_in;
         x_byte_ff    <= x_byte_in;
         res_x_ff     <= res_x_in;
         res_y_ff     <= res_y_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         buttons_ff   <= buttons_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_MAX_COL: max_col_ff <= csr_wdata[COL_W-1:0];
               CSR_MAX_ROW: max_row_ff <= csr_wdata[ROW_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_payload_ff;

endmodule

`default_nettype wire

// ===== rtl/pmc_checker.sv =====
`default_nettype none

module pmc_checker (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_valid,
   input wire logic                     req_ready,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_ready,
   input wire pmc_pkg::rsp_payload_type rsp_payload
);
   import pmc_pkg::*;

   // hold a stalled response
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response dropped or changed while stalled");

   // every accepted request shows a response in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted request produced no response");

   // a taken response with no new request leaves the output empty
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !(req_valid && req_ready) |=> !rsp_valid)
      else $error("response repeated");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_payload.updated && rsp_payload.overflow_drop))
      else $error("packet both applied and dropped");

endmodule

bind ps2_mouse_packet_cursor pmc_checker u_pmc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_payload (rsp_chan.payload)
);

`default_nettype wire

// ===== test/tb.sv =====
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pmc_pkg::*;

   localparam int QUIET_LIMIT = 1000;

   typedef struct packed {
      logic            chk;
      rsp_payload_type val;
   } typed_cursor_type;

   typedef struct packed {
      logic            func;
      logic [7:0]      data;
      logic [7:0]      nrow;
      logic [7:0]      ncol;
      logic            chk;
      rsp_payload_type val;
   } dir_row_type;

   localparam rsp_payload_type NO_RSP = '0;

   logic clock;
   logic reset;
   logic csr_we;
   csr_index_type csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   pmc_req_if req_chan ();
   pmc_rsp_if rsp_chan ();

   ps2_mouse_packet_cursor DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // cursor model state
   logic [COL_W-1:0] lim_col = MAX_COL_RESET;
   logic [ROW_W-1:0] lim_row = MAX_ROW_RESET;
   byte_pos_type     pkt_pos = POS_HEADER;
   logic [7:0]       hdr_q   = '0;
   logic [7:0]       xb_q    = '0;
   int               res_x   = 0;
   int               res_y   = 0;
   int               row_q   = int'(ROW_RESET);
   int               col_q   = int'(COL_RESET);
   logic [BTN_W-1:0] btn_q   = '0;

   rsp_payload_type  cursor_due[$];
   typed_cursor_type typed_cursor[$];

   int errors = 0;
   int sent = 0;
   int idle_pct = 0;
   int stall_left = 0;
   int quiet = 0;

   dir_row_type dir_tbl [0:24] = '{
      '{FUNC_MOUSE_BYTE, 8'h00, 8'hFF, 8'hFF, 1'b1, '{6'd12, 7'd39, 3'd0, 1'b0, 1'b0}},
      '{FUNC_SET_POS,    8'hFF, 8'hFF, 8'hFF, 1'b1, '{6'd23, 7'd78, 3'd0, 1'b1, 1'b0}},
      '{FUNC_SET_POS,    8'h00, 8'h00, 8'h00, 1'b1, '{6'd0,  7'd0,  3'd0, 1'b1, 1'b0}},
      '{FUNC_MOUSE_BYTE, 8'h0F, 8'h00, 8'h00, 1'b1, '{6'd0,  7'd0,  3'd0, 1'b0, 1'b0}},
      '{FUNC_MOUSE_BYTE, 8'h7F, 8'h00, 8'h00, 1'b0, NO_RSP},
      '{FUNC_MOUSE_BYTE, 8'h80, 8'h00, 8'h00, 1'b0, NO_RSP},
      '{FUNC_MOUSE_BYTE, 8'hC8, 8'h00, 8'h00, 1'b0, NO_RSP},
      '{FUNC_MOUSE_BYTE, 8'h55, 8'h00, 8'h00, 1'b0, NO_RSP},
      '{FUNC_MOUSE_BYTE, 8'hAA, 8'h00, 8'h00, 1'b0, NO_RSP},
      '{FUNC_MOUSE_BYTE, 8'h48, 8'h00, 8'h00, 1'b0, NO_RSP},
      '{FUNC_MOUSE_BYTE, 8'h01, 8'h00, 8'h00, 1'b0, NO_RSP},
      '{FUNC_MOUSE_BYTE, 8'h01, 8'h00, 8'h00, 1'b0, NO_RSP},
      '{FUNC_MOUSE_BYTE, 8'h88, 8'h00, 8'h00, 1'b0, NO_RSP},
      '{FUNC_MOUSE_BYTE, 8'h00, 8'h00, 8'h00, 1'b0, NO_RSP},
      '{FUNC_MOUSE_BYTE, 8'h00, 8'h00, 8'h00, 1'b0, NO_RSP},
      '{FUNC_MOUSE_BYTE, 8'h18, 8'h00, 8'h00, 1'b0, NO_RSP},
      '{FUNC_SET_POS,    8'h00, 8'd10, 8'd40, 1'b0, NO_RSP},
      '{FUNC_MOUSE_BYTE, 8'h80, 8'h00, 8'h00, 1'b0, NO_RSP},
      '{FUNC_MOUSE_BYTE, 8'h7F, 8'h00, 8'h00, 1'b0, NO_RSP},
      '{FUNC_MOUSE_BYTE, 8'h08, 8'h00, 8'h00, 1'b0, NO_RSP},
      '{FUNC_MOUSE_BYTE, 8'h01, 8'h00, 8'h00, 1'b0, NO_RSP},
      '{FUNC_MOUSE_BYTE, 8'hFF, 8'h00, 8'h00, 1'b0, NO_RSP},
      '{FUNC_MOUSE_BYTE, 8'h0C, 8'h00, 8'h00, 1'b0, NO_RSP},
      '{FUNC_MOUSE_BYTE, 8'hFF, 8'h00, 8'h00, 1'b0, NO_RSP},
      '{FUNC_MOUSE_BYTE, 8'h01, 8'h00, 8'h00, 1'b0, NO_RSP}
   };

   function automatic int step_up(int pos, int n, int lim);
      if (pos >= lim) return pos;
      if (n >= lim - pos) return lim;
      return pos + n;
   endfunction

   function automatic int step_down(int pos, int n);
      return (n >= pos) ? 0 : pos - n;
   endfunction

   function automatic rsp_payload_type advance_cursor(req_payload_type r);
      rsp_payload_type  o;
      logic signed [7:0] dxs;
      logic signed [7:0] dys;
      int sx, sy, cx, cy;
      o = '0;
      if (r.func == FUNC_SET_POS) begin
         row_q = (r.new_row > lim_row) ? int'(lim_row) : int'(r.new_row);
         col_q = (r.new_col > lim_col) ? int'(lim_col) : int'(r.new_col);
         o.updated = 1'b1;
      end else if (pkt_pos == POS_HEADER) begin
         // hold off until a byte with the sync bit shows up
         if ((r.data_byte & SYNC_MASK) != 0) begin
            hdr_q = r.data_byte;
            pkt_pos = POS_X;
         end
      end else if (pkt_pos == POS_X) begin
         xb_q = r.data_byte;
         pkt_pos = POS_Y;
      end else begin
         pkt_pos = POS_HEADER;
         if ((hdr_q & OVERFLOW_MASK) != 0) begin
            o.overflow_drop = 1'b1;
         end else begin
            dxs = xb_q;
            dys = r.data_byte;
            sx = res_x + dxs;
            sy = res_y + dys;
            cx = sx / 2;
            cy = sy / 2;
            res_x = sx - cx * 2;
            res_y = sy - cy * 2;
            btn_q = BTN_W'(hdr_q & BUTTON_MASK);
            if (cx > 0) col_q = step_up(col_q, cx, int'(lim_col));
            else if (cx < 0) col_q = step_down(col_q, -cx);
            // positive y moves toward row 0
            if (cy > 0) row_q = step_down(row_q, cy);
            else if (cy < 0) row_q = step_up(row_q, -cy, int'(lim_row));
            o.updated = 1'b1;
         end
      end
      o.cursor_row = row_q[ROW_W-1:0];
      o.cursor_col = col_q[COL_W-1:0];
      o.button_bits = btn_q;
      return o;
   endfunction

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // model update and response check
   always @(posedge clock) begin
      rsp_payload_type  pred;
      rsp_payload_type  want;
      typed_cursor_type tv;
      if (!reset) begin
         if (csr_we) begin
            case (csr_index)
               CSR_MAX_COL: lim_col = csr_wdata;
               CSR_MAX_ROW: lim_row = csr_wdata[ROW_W-1:0];
               default: ;
            endcase
         end
         if (req_chan.valid && req_chan.ready) begin
            pred = advance_cursor(req_chan.payload);
            tv = typed_cursor.pop_front();
            cursor_due.push_back(tv.chk ? tv.val : pred);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (cursor_due.size() == 0) begin
               errors++;
               $display("%0t: unexpected response, expected none, actual %h",
                        $time, rsp_chan.payload);
            end else begin
               want = cursor_due.pop_front();
               check_field("cursor_row", want.cursor_row, rsp_chan.payload.cursor_row);
               check_field("cursor_col", want.cursor_col, rsp_chan.payload.cursor_col);
               check_field("button_bits", want.button_bits, rsp_chan.payload.button_bits);
               check_field("updated", want.updated, rsp_chan.payload.updated);
               check_field("overflow_drop", want.overflow_drop,
                           rsp_chan.payload.overflow_drop);
            end
         end
      end
   end

   // response side backpressure
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_chan.ready <= 1'b0;
      end else if (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct) begin
         stall_left <= $urandom_range(0, 8);
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet <= 0;
      else
         quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic send_item(input logic func, input logic [7:0] data,
                            input logic [7:0] nrow, input logic [7:0] ncol,
                            input logic chk, input rsp_payload_type val);
      req_payload_type p;
      int gap;
      if (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct) begin
         gap = $urandom_range(1, 9);
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      p.func = func;
      p.data_byte = data;
      p.new_row = nrow;
      p.new_col = ncol;
      typed_cursor.push_back('{chk, val});
      req_chan.valid <= 1'b1;
      req_chan.payload <= p;
      do @(posedge clock); while (!req_chan.ready);
      sent++;
   endtask

   task automatic mouse_byte(input logic [7:0] data);
      send_item(FUNC_MOUSE_BYTE, data, 8'($urandom), 8'($urandom), 1'b0, NO_RSP);
   endtask

   function automatic logic [7:0] rand_pos(int lim);
      int v;
      case ($urandom_range(0, 3))
         0: v = 0;
         1: v = lim + $urandom_range(0, 2) - 1;
         default: v = $urandom_range(0, 255);
      endcase
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return v[7:0];
   endfunction

   task automatic set_pos_rand();
      send_item(FUNC_SET_POS, 8'($urandom), rand_pos(int'(lim_row)),
                rand_pos(int'(lim_col)), 1'b0, NO_RSP);
   endtask

   function automatic logic [7:0] rand_delta();
      case ($urandom_range(0, 4))
         0, 1: return 8'($urandom_range(0, 6) - 3);
         2: begin
            case ($urandom_range(0, 3))
               0: return 8'h7F;
               1: return 8'h80;
               2: return 8'h01;
               default: return 8'hFF;
            endcase
         end
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic random_items(int n);
      int start;
      logic [1:0] ovf;
      start = sent;
      while (sent - start < n) begin
         case ($urandom_range(0, 9))
            0: set_pos_rand();
            1: mouse_byte(8'($urandom));
            default: begin
               ovf = ($urandom_range(0, 5) == 0) ? 2'($urandom_range(1, 3)) : 2'b00;
               mouse_byte({ovf, 2'($urandom), 1'b1, 3'($urandom)});
               // break the packet now and then with a position request
               if ($urandom_range(0, 19) == 0) set_pos_rand();
               mouse_byte(rand_delta());
               mouse_byte(rand_delta());
            end
         endcase
      end
   endtask

   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      // let the last accepted request reach the expected queue first
      @(posedge clock);
      while (cursor_due.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_cfg(int max_c, int max_r);
      csr_we <= 1'b1;
      csr_index <= CSR_MAX_COL;
      csr_wdata <= CSR_DATA_W'(max_c);
      @(posedge clock);
      csr_index <= CSR_MAX_ROW;
      csr_wdata <= CSR_DATA_W'(max_r);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= CSR_MAX_COL;
      csr_wdata <= '0;
      req_chan.valid <= 1'b0;
      req_chan.payload <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      write_cfg(int'(MAX_COL_RESET), int'(MAX_ROW_RESET));
      idle_pct = 20;
      foreach (dir_tbl[i])
         send_item(dir_tbl[i].func, dir_tbl[i].data, dir_tbl[i].nrow, dir_tbl[i].ncol,
                   dir_tbl[i].chk, dir_tbl[i].val);
      wait_idle();

      write_cfg(127, 63);
      idle_pct = 25;
      random_items(200);
      wait_idle();

      write_cfg(0, 0);
      random_items(80);
      wait_idle();

      write_cfg($urandom_range(0, 127), $urandom_range(0, 63));
      idle_pct = 40;
      random_items(200);
      wait_idle();

      // park the cursor high, then lower the limits below it
      write_cfg(127, 63);
      send_item(FUNC_SET_POS, 8'h00, 8'hFF, 8'hFF, 1'b0, NO_RSP);
      wait_idle();
      write_cfg(9, 4);
      idle_pct = 20;
      random_items(150);
      wait_idle();

      write_cfg(int'(MAX_COL_RESET), int'(MAX_ROW_RESET));
      idle_pct = 0;
      random_items(200);
      wait_idle();

      write_cfg($urandom_range(1, 127), $urandom_range(1, 63));
      random_items(200);
      wait_idle();

      repeat (20) @(posedge clock);
      if (errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule

// ===== sim.f =====
rtl/pmc_pkg.sv
rtl/pmc_req_if.sv
rtl/pmc_rsp_if.sv
rtl/ps2_mouse_packet_cursor.sv
rtl/pmc_checker.sv
test/tb.sv
